// File: src/keypad_word_matcher_assert.svh
// assertion macros shared by the keypad word matcher modules
// expects clk and rst in the scope of the module that uses them
`ifndef KEYPAD_WORD_MATCHER_ASSERT_SVH
`define KEYPAD_WORD_MATCHER_ASSERT_SVH

// same-cycle implication, held off during reset
`define KWM_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keypad word matcher check failed");

// next-cycle implication, held off during reset
`define KWM_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad word matcher check failed");

`endif

// File: src/kwm_pkg.sv
// shared types, sizes, codes and keypad lookup for the keypad word matcher
// no dependencies
package kwm_pkg;

  localparam int MAX_WORDS = 32;
  localparam int MAX_LEN   = 16;

  localparam int LIDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int WIDX_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int LPOS_W  = $clog2(MAX_LEN + 1);
  localparam int TOT_W   = $clog2(MAX_WORDS + 1);
  localparam int ADDR_W  = WIDX_W + LIDX_W;
  localparam int RAM_DEPTH = MAX_WORDS * (1 << LIDX_W);
  localparam int SYM_W   = 8;
  localparam int FUNC_W  = 2;
  localparam int VALUE_W = 6;

  typedef logic [LIDX_W-1:0]  lidx_t;
  typedef logic [WIDX_W-1:0]  widx_t;
  typedef logic [LPOS_W-1:0]  lpos_t;
  typedef logic [TOT_W-1:0]   total_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [SYM_W-1:0]   sym_t;
  typedef logic [FUNC_W-1:0]  func_t;
  typedef logic [VALUE_W-1:0] value_t;

  // operation codes on the input side
  localparam func_t FUNC_WORD  = 2'd0;
  localparam func_t FUNC_QUERY = 2'd1;
  localparam func_t FUNC_CLEAR = 2'd2;

  // result kinds
  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_INDEX = 1'b1;

  localparam sym_t CHAR_TWO  = "2";
  localparam sym_t CHAR_NINE = "9";

  // letter range of each key, key 2 first
  localparam sym_t GRP_LO [8] = '{"a", "d", "g", "j", "m", "p", "t", "w"};
  localparam sym_t GRP_HI [8] = '{"c", "f", "i", "l", "o", "s", "v", "z"};

  // controller to datapath
  typedef struct packed {
    logic word_char;
    logic query_char;
    logic dict_clear;
    logic scan_start;
    logic next_word;
    logic hit;
    logic read_letter;
    logic next_letter;
    logic emit_cnt;
    logic emit_idx;
    logic ptr_step;
    logic query_clear;
  } kwm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic word_skip;
    logic letter_ok;
    logic letter_last;
    logic count_zero;
    logic ptr_hit;
    logic emit_last;
    logic out_free;
  } kwm_status_t;

  function automatic logic key_fits(input sym_t digit, input sym_t letter);
    logic [2:0] g;
    g = 3'(digit - CHAR_TWO);
    return (digit >= CHAR_TWO) && (digit <= CHAR_NINE) &&
           (letter >= GRP_LO[g]) && (letter <= GRP_HI[g]);
  endfunction

endpackage

// File: src/kwm_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module kwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic                                          rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/kwm_datapath.sv
// dictionary store, query buffer, scan counters and result register
// depends on kwm_pkg, kwm_ram and keypad_word_matcher_assert.svh
`include "keypad_word_matcher_assert.svh"

module kwm_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  kwm_pkg::kwm_cmd_t    cmd,
  input  kwm_pkg::sym_t        sym,
  input  logic                 last,
  output kwm_pkg::kwm_status_t status,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,
  output logic [0:0]           m_tuser,
  output logic                 m_tlast
);

  // dictionary
  kwm_pkg::lpos_t  word_sizes [kwm_pkg::MAX_WORDS];
  logic [kwm_pkg::MAX_WORDS-1:0] word_bad;
  kwm_pkg::total_t total;
  kwm_pkg::lpos_t  lpos;
  logic            load_bad;

  // query
  kwm_pkg::sym_t   qsym [kwm_pkg::MAX_LEN];
  kwm_pkg::lpos_t  qsize;
  logic            overflow;

  // scan and emit
  kwm_pkg::total_t scan_w;
  kwm_pkg::lidx_t  lidx;
  kwm_pkg::total_t count;
  kwm_pkg::total_t left;
  kwm_pkg::widx_t  ptr;
  logic [kwm_pkg::MAX_WORDS-1:0] match_bits;

  logic            lpos_room;
  kwm_pkg::lpos_t  lpos_next;
  logic            dict_room;
  logic            ram_wr_en;
  kwm_pkg::addr_t  ram_wr_addr;
  kwm_pkg::addr_t  ram_rd_addr;
  kwm_pkg::sym_t   ram_rd_data;
  kwm_pkg::widx_t  scan_idx;

  function automatic kwm_pkg::widx_t scan_idx_of(input kwm_pkg::total_t t);
    return t[kwm_pkg::WIDX_W-1:0];
  endfunction

  always_comb begin
    lpos_room   = lpos < kwm_pkg::lpos_t'(kwm_pkg::MAX_LEN);
    lpos_next   = lpos_room ? lpos + kwm_pkg::lpos_t'(1) : lpos;
    dict_room   = total < kwm_pkg::total_t'(kwm_pkg::MAX_WORDS);
    ram_wr_en   = cmd.word_char && dict_room && lpos_room;
    ram_wr_addr = {total[kwm_pkg::WIDX_W-1:0], lpos[kwm_pkg::LIDX_W-1:0]};
    scan_idx    = scan_w[kwm_pkg::WIDX_W-1:0];
    ram_rd_addr = {scan_idx, lidx};
  end

  kwm_ram #(
    .WIDTH (kwm_pkg::SYM_W),
    .DEPTH (kwm_pkg::RAM_DEPTH)
  ) u_letters (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (sym),
    .rd_en   (cmd.read_letter),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    status.scan_done   = (scan_w == total) || overflow;
    status.word_skip   = word_bad[scan_idx] || (word_sizes[scan_idx] != qsize);
    status.letter_ok   = kwm_pkg::key_fits(qsym[lidx], ram_rd_data);
    status.letter_last = (kwm_pkg::lpos_t'(lidx) + kwm_pkg::lpos_t'(1)) == qsize;
    status.count_zero  = count == '0;
    status.ptr_hit     = match_bits[ptr];
    status.emit_last   = left == kwm_pkg::total_t'(1);
    status.out_free    = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      lpos     <= '0;
      load_bad <= 1'b0;
      qsize    <= '0;
      overflow <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // word loading
      if (cmd.word_char) begin
        if (dict_room && last) begin
          word_sizes[scan_idx_of(total)] <= lpos_next;
          word_bad[scan_idx_of(total)]   <= load_bad || !lpos_room;
          total <= total + kwm_pkg::total_t'(1);
        end
        if (last) begin
          lpos     <= '0;
          load_bad <= 1'b0;
        end else if (dict_room) begin
          lpos <= lpos_next;
          if (!lpos_room) begin
            load_bad <= 1'b1;
          end
        end
      end
      if (cmd.dict_clear) begin
        total    <= '0;
        lpos     <= '0;
        load_bad <= 1'b0;
      end

      // query buffering
      if (cmd.query_char) begin
        if (qsize < kwm_pkg::lpos_t'(kwm_pkg::MAX_LEN)) begin
          qsym[qsize[kwm_pkg::LIDX_W-1:0]] <= sym;
          qsize <= qsize + kwm_pkg::lpos_t'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.query_clear) begin
        qsize    <= '0;
        overflow <= 1'b0;
      end

      // result register
      if (cmd.emit_cnt || cmd.emit_idx) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end

    // scan, no reset needed as every scan starts with scan_start
    if (cmd.scan_start) begin
      scan_w     <= '0;
      lidx       <= '0;
      count      <= '0;
      match_bits <= '0;
    end
    if (cmd.next_word) begin
      scan_w <= scan_w + kwm_pkg::total_t'(1);
      lidx   <= '0;
    end
    if (cmd.hit) begin
      match_bits[scan_idx] <= 1'b1;
      count <= count + kwm_pkg::total_t'(1);
    end
    if (cmd.next_letter) begin
      lidx <= lidx + kwm_pkg::lidx_t'(1);
    end
    if (cmd.emit_cnt) begin
      m_tdata    <= 8'(count);
      m_tuser[0] <= kwm_pkg::KIND_COUNT;
      m_tlast    <= count == '0;
      left       <= count;
      ptr        <= '0;
    end
    if (cmd.emit_idx) begin
      m_tdata    <= 8'(ptr);
      m_tuser[0] <= kwm_pkg::KIND_INDEX;
      m_tlast    <= left == kwm_pkg::total_t'(1);
      left       <= left - kwm_pkg::total_t'(1);
    end
    if (cmd.ptr_step) begin
      ptr <= ptr + kwm_pkg::widx_t'(1);
    end
  end

  `KWM_CHECK(a_emit_free, (cmd.emit_cnt || cmd.emit_idx), status.out_free)
  `KWM_CHECK(a_total_cap, 1'b1, total <= kwm_pkg::total_t'(kwm_pkg::MAX_WORDS))
  `KWM_CHECK(a_left_live, cmd.emit_idx, (left != '0) && match_bits[ptr])

endmodule

// File: src/kwm_ctrl.sv
// controller state machine: input acceptance, dictionary scan, result sequencing
// depends on kwm_pkg and keypad_word_matcher_assert.svh
`include "keypad_word_matcher_assert.svh"

module kwm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  kwm_pkg::func_t       func,
  input  logic                 last,
  input  kwm_pkg::kwm_status_t status,
  output kwm_pkg::kwm_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WORD,
    S_RD,
    S_CMP,
    S_CNT,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (func)
            kwm_pkg::FUNC_WORD: begin
              cmd.word_char = 1'b1;
            end
            kwm_pkg::FUNC_QUERY: begin
              cmd.query_char = 1'b1;
              if (last) begin
                cmd.scan_start = 1'b1;
                state_next     = S_WORD;
              end
            end
            kwm_pkg::FUNC_CLEAR: begin
              cmd.dict_clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_WORD: begin
        if (status.scan_done) begin
          state_next = S_CNT;
        end else if (status.word_skip) begin
          cmd.next_word = 1'b1;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.read_letter = 1'b1;
        state_next      = S_CMP;
      end
      S_CMP: begin
        if (!status.letter_ok) begin
          cmd.next_word = 1'b1;
          state_next    = S_WORD;
        end else if (status.letter_last) begin
          cmd.next_word = 1'b1;
          cmd.hit       = 1'b1;
          state_next    = S_WORD;
        end else begin
          cmd.next_letter = 1'b1;
          state_next      = S_RD;
        end
      end
      S_CNT: begin
        if (status.out_free) begin
          cmd.emit_cnt = 1'b1;
          if (status.count_zero) begin
            cmd.query_clear = 1'b1;
            state_next      = S_IDLE;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!status.ptr_hit) begin
          cmd.ptr_step = 1'b1;
        end else if (status.out_free) begin
          cmd.emit_idx = 1'b1;
          cmd.ptr_step = 1'b1;
          if (status.emit_last) begin
            cmd.query_clear = 1'b1;
            state_next      = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `KWM_CHECK_NEXT(a_scan_begin,
    s_tvalid && s_tready && (func == kwm_pkg::FUNC_QUERY) && last, state == S_WORD)

endmodule

// File: src/keypad_word_matcher.sv
// keypad word matcher top level: stream ports, controller and datapath
// depends on kwm_pkg, kwm_ctrl and kwm_datapath
//
// phone keypad (2=abc .. 9=wxyz) word matcher. words are loaded one letter a
// transaction (tuser=0, tlast on the final letter) into a store of up to
// MAX_WORDS words of MAX_LEN letters; tuser=2 empties the store. query digits
// arrive with tuser=1; tlast on the final digit starts a scan, after which a
// count transaction (tuser=0) comes out, followed by one transaction per
// matching word carrying its load index (tuser=1), tlast on the last one.
// overlong words never match, words beyond capacity are dropped and an
// overlong query reports a count of zero. letters and digits are taken back
// to back. a query end holds the input off while the letter memory is
// scanned through its single read port: each stored word is checked for
// length (none for an overlong query), then each letter of a word of the
// right length is read and compared, up to the first mismatch; then the
// scan closes, the count goes out and each word position up to the last
// match is visited, stretched by any output back-pressure. a finished result
// sits in the output register, so new input is taken while it waits

module keypad_word_matcher (
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol
  input  logic [1:0] s_tuser,   // [1:0] func
  input  logic       s_tlast,   // last
  // result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [5:0] value, [7:6] zero
  output logic [0:0] m_tuser,   // [0] kind
  output logic       m_tlast    // final_res
);

  kwm_pkg::kwm_cmd_t    cmd;
  kwm_pkg::kwm_status_t status;

  // sequencing: which transaction is taken, scan and emit order
  kwm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (s_tuser),
    .last     (s_tlast),
    .status   (status),
    .cmd      (cmd)
  );

  // storage, comparison and the output register
  kwm_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sym      (s_tdata),
    .last     (s_tlast),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
